@@ hdl/smfx_pkg.sv @@
// Package for the sign-magnitude fixed-point ALU: operation and status codes,
// default format constants and the transaction structs. Depends on nothing.
package smfx_pkg;

	localparam int DefIntBits  = 32;
	localparam int DefFracBits = 32;
	localparam int MagW        = 64;
	// Quotient bits retired per divider stage; sets the divider's depth.
	localparam int DivStep     = 8;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_SHR   = 3'd4,
		OP_FLOOR = 3'd5,
		OP_CEIL  = 3'd6,
		OP_NONE  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]      opcode;
		logic            a_sign;
		logic [MagW-1:0] a_mag;
		logic            b_sign;
		logic [MagW-1:0] b_mag;
		logic [6:0]      shift_k;
	} in_item_t;

	typedef struct packed {
		logic            r_sign;
		logic [MagW-1:0] r_mag;
		logic [1:0]      status;
	} out_item_t;

	// Classified operation handed from the front end to the back end.
	typedef struct packed {
		op_t             op;
		logic            a_sign;
		logic [MagW-1:0] a_mag;
		logic            b_sign;
		logic [MagW-1:0] b_mag;
		logic [6:0]      shift_k;
		logic            a_zero;
		logic            b_zero;
	} task_t;

endpackage

@@ hdl/smfx_front.sv @@
// Front end of the sign-magnitude ALU: masks operands to the format width,
// cleans negative zeros and decodes the operation. Uses smfx_pkg.
module smfx_front import smfx_pkg::*; #(
	parameter int INT_BITS  = DefIntBits,
	parameter int FRAC_BITS = DefFracBits
) (
	input  in_item_t item,
	output task_t    tsk
);
	localparam int TotBits = (INT_BITS + FRAC_BITS > MagW) ? MagW : INT_BITS + FRAC_BITS;
	localparam logic [MagW-1:0] MagMask = {MagW{1'b1}} >> (MagW - TotBits);

	logic [MagW-1:0] am, bm;

	always_comb begin
		am = item.a_mag & MagMask;
		bm = item.b_mag & MagMask;
		tsk.op      = op_t'(item.opcode);
		tsk.a_mag   = am;
		tsk.b_mag   = bm;
		tsk.a_zero  = (am == '0);
		tsk.b_zero  = (bm == '0);
		tsk.a_sign  = item.a_sign & (am != '0);
		tsk.b_sign  = item.b_sign & (bm != '0);
		tsk.shift_k = item.shift_k;
	end
endmodule

@@ hdl/smfx_fifo.sv @@
// Small two-entry queue of classified tasks between the front and back ends.
// Uses smfx_pkg.
module smfx_fifo import smfx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  task_t wdata,
	output logic  full,
	input  logic  rd,
	output logic  vld,
	output task_t rdata
);
	task_t mem_q [2];
	logic  wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q[1];
	assign vld   = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && vld) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr && !full} - {1'b0, rd && vld};
		end
	end
endmodule

@@ hdl/smfx_div.sv @@
// Pipelined restoring divider for the back end: one quotient bit per step,
// registered every DivStep bits. The divisor and valid flag follow the quotient. Uses smfx_pkg.
module smfx_div import smfx_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [MagW-1:0] num_hi,
	input  logic [MagW-1:0] num_lo,
	input  logic [MagW-1:0] den,
	output logic            out_vld,
	output logic [MagW-1:0] q_hi,
	output logic [MagW-1:0] q_lo,
	output logic            rem_nz
);
	localparam int NBits = 2 * MagW;
	localparam int Steps = DivStep;
	localparam int NStg  = NBits / Steps;

	logic [MagW-1:0]  r_s   [NStg+1];
	logic [NBits-1:0] n_s   [NStg+1];
	logic [MagW-1:0]  d_s   [NStg+1];
	logic             v_s   [NStg+1];

	assign r_s[0] = '0;
	assign n_s[0] = {num_hi, num_lo};
	assign d_s[0] = den;
	assign v_s[0] = in_vld;

	for (genvar g = 0; g < NStg; g++) begin : g_stg
		logic [MagW-1:0]  r_c;
		logic [NBits-1:0] n_c;
		logic [MagW-1:0]  r_q;
		logic [NBits-1:0] n_q;
		logic [MagW-1:0]  d_q;
		logic             v_q;
		always_comb begin
			logic carry;
			r_c = r_s[g];
			n_c = n_s[g];
			for (int i = 0; i < Steps; i++) begin
				carry = r_c[MagW-1];
				r_c   = {r_c[MagW-2:0], n_c[NBits-1]};
				n_c   = {n_c[NBits-2:0], 1'b0};
				if (carry || r_c >= d_s[g]) begin
					r_c    = r_c - d_s[g];
					n_c[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_q <= r_c;
				n_q <= n_c;
				d_q <= d_s[g];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q <= 1'b0;
			else if (en) v_q <= v_s[g];
		end
		assign r_s[g+1] = r_q;
		assign n_s[g+1] = n_q;
		assign d_s[g+1] = d_q;
		assign v_s[g+1] = v_q;
	end

	assign out_vld = v_s[NStg];
	assign q_hi    = n_s[NStg][NBits-1:MagW];
	assign q_lo    = n_s[NStg][MagW-1:0];
	assign rem_nz  = (r_s[NStg] != '0);
endmodule

@@ hdl/smfx_back.sv @@
// Back end of the sign-magnitude ALU: a fixed-latency pipeline that executes
// every operation and a result queue that absorbs stalls. Uses smfx_pkg and smfx_div.
module smfx_back import smfx_pkg::*; #(
	parameter int INT_BITS  = DefIntBits,
	parameter int FRAC_BITS = DefFracBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      round_up,
	input  logic      tsk_vld,
	input  task_t     tsk,
	output logic      tsk_take,
	output logic      res_empty,
	input  logic      res_pop,
	output out_item_t res
);
	localparam int TotBits = (INT_BITS + FRAC_BITS > MagW) ? MagW : INT_BITS + FRAC_BITS;
	localparam logic [MagW-1:0] MagMask  = {MagW{1'b1}} >> (MagW - TotBits);
	localparam logic [MagW-1:0] FracMask = (MagW'(1) << FRAC_BITS) - MagW'(1);
	localparam logic [MagW-1:0] IpMax    = MagMask >> FRAC_BITS;
	localparam int Lat   = 2 * MagW / DivStep;  // divider stages
	localparam int QD    = Lat + 4;             // result queue depth covers latency
	localparam int QAW   = $clog2(QD);
	localparam int CW    = $clog2(QD + 1);

	// Credit check: accept a task only when the result queue can hold it.
	logic [CW-1:0] used_q;   // tasks in flight plus results waiting
	logic pop_ok;
	assign pop_ok   = res_pop && !res_empty;
	assign tsk_take = tsk_vld && (used_q < CW'(QD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) used_q <= '0;
		else used_q <= used_q + CW'(tsk_take) - CW'(pop_ok);
	end

	// Stage 1: multiply partial products (32x32 each), add/sub, shift, floor/ceil.
	logic            v_s1, away_s1, mul_s1, div_s1, dz_s1;
	logic            sgn_s1;
	logic [MagW-1:0] mag_s1;
	logic [1:0]      st_s1;
	logic [MagW-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [MagW-1:0] am_s1;

	logic            sgn_c, away_c;
	logic [MagW-1:0] mag_c;
	logic [1:0]      st_c;
	logic [MagW:0]   sum_c;
	logic            bs_c;

	always_comb begin
		logic [MagW-1:0] lostm;
		logic [MagW-1:0] ip;
		logic up;
		sgn_c  = 1'b0;
		mag_c  = '0;
		st_c   = ST_OK;
		bs_c   = tsk.b_sign;
		sum_c  = '0;
		lostm  = '0;
		ip     = '0;
		up     = 1'b0;
		away_c = 1'b0;
		unique case (tsk.op)
			OP_ADD, OP_SUB: begin
				if (tsk.op == OP_SUB && !tsk.b_zero) bs_c = ~tsk.b_sign;
				sum_c = {1'b0, tsk.a_mag} + {1'b0, tsk.b_mag};
				if (tsk.a_zero) begin
					sgn_c = bs_c; mag_c = tsk.b_mag;
				end else if (tsk.b_zero) begin
					sgn_c = tsk.a_sign; mag_c = tsk.a_mag;
				end else if (tsk.a_sign == bs_c) begin
					if (sum_c[MagW] || ((sum_c[MagW-1:0] & ~MagMask) != '0)) st_c = ST_OVF;
					else begin
						sgn_c = tsk.a_sign; mag_c = sum_c[MagW-1:0];
					end
				end else if (tsk.a_mag < tsk.b_mag) begin
					sgn_c = bs_c; mag_c = tsk.b_mag - tsk.a_mag;
				end else begin
					sgn_c = tsk.a_sign; mag_c = tsk.a_mag - tsk.b_mag;
				end
			end
			OP_MUL, OP_DIV: begin
				sgn_c  = tsk.a_sign ^ tsk.b_sign;
				away_c = sgn_c != round_up;
			end
			OP_SHR: begin
				sgn_c = tsk.a_sign;
				away_c = tsk.a_sign != round_up;
				if (tsk.a_zero || tsk.shift_k == 7'd0) mag_c = tsk.a_mag;
				else if (tsk.shift_k >= 7'(MagW)) mag_c = MagW'(away_c);
				else begin
					lostm = (MagW'(1) << tsk.shift_k[5:0]) - MagW'(1);
					mag_c = (tsk.a_mag >> tsk.shift_k[5:0])
						+ MagW'(away_c && ((tsk.a_mag & lostm) != '0));
				end
			end
			OP_FLOOR, OP_CEIL: begin
				sgn_c = tsk.a_sign;
				ip    = tsk.a_mag >> FRAC_BITS;
				up    = (tsk.op == OP_FLOOR) ? tsk.a_sign : !tsk.a_sign;
				if (up && ((tsk.a_mag & FracMask) != '0)) begin
					if (ip == IpMax) st_c = ST_OVF;
					else ip = ip + MagW'(1);
				end
				mag_c = ip << FRAC_BITS;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tsk_take) begin
			sgn_s1  <= sgn_c;
			mag_s1  <= mag_c;
			st_s1   <= st_c;
			away_s1 <= away_c;
			mul_s1  <= (tsk.op == OP_MUL) && !tsk.a_zero && !tsk.b_zero;
			div_s1  <= (tsk.op == OP_DIV);
			dz_s1   <= tsk.b_zero;
			am_s1   <= tsk.a_mag;
			ll_s1   <= tsk.a_mag[31:0]  * tsk.b_mag[31:0];
			lh_s1   <= tsk.a_mag[31:0]  * tsk.b_mag[63:32];
			hl_s1   <= tsk.a_mag[63:32] * tsk.b_mag[31:0];
			hh_s1   <= tsk.a_mag[63:32] * tsk.b_mag[63:32];
		end
	end

	// The pipeline always advances; the queue credit guarantees room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= tsk_take;
	end

	// Stage 1 also launches the divider with the same operands, a zero divisor replaced by one.
	logic [MagW-1:0] b_div_s1;
	always_ff @(posedge clk) begin
		if (tsk_take) b_div_s1 <= tsk.b_zero ? MagW'(1) : tsk.b_mag;
	end

	// Stage 2: combine partial products, shift and round the product.
	logic            sgn_s2;
	logic [MagW-1:0] mag_s2;
	logic [1:0]      st_s2;
	logic            div_s2, dz_s2, away_s2, nz_s2;

	logic [MagW-1:0] mid_c, lo_c, hi_c, slo_c, shi_c;
	logic [1:0]      pst_c;
	logic [MagW-1:0] pmag_c;
	always_comb begin
		mid_c = (ll_s1 >> 32) + {32'd0, lh_s1[31:0]} + {32'd0, hl_s1[31:0]};
		lo_c  = {mid_c[31:0], ll_s1[31:0]};
		hi_c  = hh_s1 + (lh_s1 >> 32) + (hl_s1 >> 32) + (mid_c >> 32);
		slo_c = (lo_c >> FRAC_BITS) | (hi_c << (MagW - FRAC_BITS));
		shi_c = hi_c >> FRAC_BITS;
		pst_c = st_s1;
		pmag_c = mag_s1;
		if (mul_s1) begin
			if (shi_c != '0 || (slo_c & ~MagMask) != '0) pst_c = ST_OVF;
			else begin
				pmag_c = slo_c;
				if (away_s1 && (lo_c & FracMask) != '0) begin
					if (slo_c == MagMask) pst_c = ST_OVF;
					else pmag_c = slo_c + MagW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		sgn_s2  <= sgn_s1;
		mag_s2  <= pmag_c;
		st_s2   <= pst_c;
		div_s2  <= div_s1;
		dz_s2   <= dz_s1;
		away_s2 <= away_s1;
		nz_s2   <= (am_s1 != '0);
	end

	// Delay line matching the divider's latency.
	logic            dv;
	logic [MagW-1:0] qh, ql;
	logic            rnz;
	smfx_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (1'b1),
		.in_vld (v_s1),
		.num_hi (am_s1 >> (MagW - FRAC_BITS)),
		.num_lo (am_s1 << FRAC_BITS),
		.den    (b_div_s1),
		.out_vld(dv),
		.q_hi   (qh),
		.q_lo   (ql),
		.rem_nz (rnz)
	);

	localparam int DL = Lat - 1;
	logic            dsgn_q [DL];
	logic [MagW-1:0] dmag_q [DL];
	logic [1:0]      dst_q  [DL];
	logic            ddiv_q [DL], ddz_q [DL], daway_q [DL], dnz_q [DL];
	always_ff @(posedge clk) begin
		dsgn_q[0] <= sgn_s2; dmag_q[0] <= mag_s2; dst_q[0] <= st_s2;
		ddiv_q[0] <= div_s2; ddz_q[0] <= dz_s2; daway_q[0] <= away_s2;
		dnz_q[0]  <= nz_s2;
		for (int i = 1; i < DL; i++) begin
			dsgn_q[i] <= dsgn_q[i-1]; dmag_q[i] <= dmag_q[i-1];
			dst_q[i] <= dst_q[i-1]; ddiv_q[i] <= ddiv_q[i-1];
			ddz_q[i] <= ddz_q[i-1]; daway_q[i] <= daway_q[i-1];
			dnz_q[i] <= dnz_q[i-1];
		end
	end

	// Final: finish division, apply error and zero rules.
	out_item_t fin_c;
	always_comb begin
		logic            s;
		logic [MagW-1:0] m;
		logic [1:0]      st;
		s  = dsgn_q[DL-1];
		m  = dmag_q[DL-1];
		st = dst_q[DL-1];
		if (ddiv_q[DL-1]) begin
			if (ddz_q[DL-1]) st = ST_DIV0;
			else if (dnz_q[DL-1]) begin
				if (qh != '0 || (ql & ~MagMask) != '0) st = ST_OVF;
				else begin
					m = ql;
					if (daway_q[DL-1] && rnz) begin
						if (ql == MagMask) st = ST_OVF;
						else m = ql + MagW'(1);
					end
				end
			end
		end
		if (st != ST_OK) m = '0;
		m = m & MagMask;
		fin_c.r_sign = s && (m != '0);
		fin_c.r_mag  = m;
		fin_c.status = st;
	end

	// Result queue.
	out_item_t       rq_q [QD];
	logic [QAW-1:0]  wp_q, rp_q;
	logic [CW-1:0]   cnt_q;
	always_ff @(posedge clk) begin
		if (dv) rq_q[wp_q] <= fin_c;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (dv) wp_q <= (wp_q == QAW'(QD - 1)) ? '0 : wp_q + QAW'(1);
			if (pop_ok) rp_q <= (rp_q == QAW'(QD - 1)) ? '0 : rp_q + QAW'(1);
			cnt_q <= cnt_q + CW'(dv) - CW'(pop_ok);
		end
	end
	assign res_empty = (cnt_q == '0);
	assign res       = rq_q[rp_q];
endmodule

@@ hdl/signmag_fixed_point_alu.sv @@
// Top level of the sign-magnitude fixed-point ALU.
// Uses smfx_pkg, smfx_front, smfx_fifo and smfx_back.
//
// Accepts one transaction per clock, while full is low, on a queue-style
// push/full port and returns one result per operation, in order, on an
// empty/pop port. Every operation runs through the same pipeline: the front
// queue, the first back-end stage and the restoring divider, which retires
// eight quotient bits per stage over its 128-bit dividend, and its result
// is then written into the result queue. Add, subtract, multiply, shift,
// floor and ceiling ride alongside in a delay line so that results stay in
// order. Throughput is one operation per cycle as long as results are popped;
// the back end admits a task only while fewer than twenty are in flight or
// waiting, so with no pops full rises after twenty-two transactions, the
// last two held in the front queue. The rounding direction register
// round_up must be written only while the unit is idle.
module signmag_fixed_point_alu import smfx_pkg::*; #(
	parameter int INT_BITS  = DefIntBits,
	parameter int FRAC_BITS = DefFracBits
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  in_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);
	logic  round_up_q;
	task_t front_tsk, q_tsk;
	logic  q_vld, q_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) round_up_q <= 1'b0;
		else if (cfg_we) round_up_q <= cfg_wdata;
	end

	// The front end classifies the incoming transaction.
	smfx_front #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
		.item (in_item),
		.tsk  (front_tsk)
	);

	// A short queue decouples the front end from the back end's credit stall.
	smfx_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (front_tsk),
		.full  (full),
		.rd    (q_take),
		.vld   (q_vld),
		.rdata (q_tsk)
	);

	smfx_back #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.round_up (round_up_q),
		.tsk_vld  (q_vld),
		.tsk      (q_tsk),
		.tsk_take (q_take),
		.res_empty(empty),
		.res_pop  (pop),
		.res      (out_item)
	);
endmodule

@@ hdl/smfx_checker.sv @@
// Port-level checker for the sign-magnitude ALU, bound to the top level.
// Uses smfx_pkg.
module smfx_checker import smfx_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_item_t out_item
);
	// While reset is held both queues are empty.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !full && empty)
		else $error("queues not idle in reset");
	// A zero result must be positive.
	a_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.r_mag == '0 |-> !out_item.r_sign)
		else $error("negative zero result");
	// Errors give a zero magnitude.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.status != ST_OK |-> out_item.r_mag == '0)
		else $error("error result not zero");
	// Status code 3 never appears.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.status != ST_RSVD)
		else $error("reserved status");
	// A waiting result holds while not popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item))
		else $error("result changed while waiting");
endmodule

bind signmag_fixed_point_alu smfx_checker u_chk (
	.clk(clk), .arst_n(arst_n), .full(full),
	.empty(empty), .pop(pop), .out_item(out_item)
);
